FILE: src/mfpp_pkg.sv
`default_nettype none

package mfpp_pkg;

    localparam logic [7:0] MARKER_BYTE  = 8'hFF;
    localparam logic [7:0] TYPE_POS     = 8'd1;
    localparam logic [7:0] TYPE_POS_DES = 8'd2;

    localparam logic [4:0] PARITY_IDX = 5'd1;
    localparam logic [4:0] TARGET_IDX = 5'd2;
    localparam logic [4:0] TYPE_IDX   = 5'd3;
    localparam logic [4:0] HEADER_LEN = 5'd4;
    localparam logic [4:0] DATA_END   = 5'd15;
    localparam logic [4:0] LAST_IDX   = 5'd19;

    localparam int DATA_BYTES = 12;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [31:0] x_word;
        logic [31:0] y_word;
        logic [31:0] z_word;
    } res_t;

endpackage

`default_nettype wire

FILE: src/mfpp_in_stage.sv
`default_nettype none

module mfpp_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       advance,
    output logic            in_valid,
    output logic [7:0]      in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

FILE: src/mfpp_core.sv
`default_nettype none

module mfpp_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire logic [7:0] in_byte,
    output mfpp_pkg::res_t  res
);

    logic       open_reg;
    logic       open_next;
    logic [4:0] count_reg;
    logic [4:0] count_next;
    logic [7:0] parity_reg;
    logic [7:0] parity_next;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [7:0] type_reg;
    logic [7:0] type_next;
    logic [7:0] data_reg [mfpp_pkg::DATA_BYTES];
    logic       take;
    logic [4:0] cnt;
    logic [4:0] data_off;
    logic [3:0] data_idx;

    always_comb begin
        take        = fire && (open_reg || (in_byte == mfpp_pkg::MARKER_BYTE));
        cnt         = open_reg ? count_reg : 5'd0;
        data_off    = cnt - mfpp_pkg::HEADER_LEN;
        data_idx    = data_off[3:0];
        open_next   = open_reg;
        count_next  = count_reg;
        parity_next = parity_reg;
        acc_next    = acc_reg;
        type_next   = type_reg;
        res.valid   = 1'b0;
        res.kind    = (type_reg == mfpp_pkg::TYPE_POS_DES);
        res.x_word  = {data_reg[3], data_reg[2], data_reg[1], data_reg[0]};
        res.y_word  = {data_reg[7], data_reg[6], data_reg[5], data_reg[4]};
        res.z_word  = {data_reg[11], data_reg[10], data_reg[9], data_reg[8]};
        if (take) begin
            open_next  = 1'b1;
            count_next = cnt + 5'd1;
            if (cnt == mfpp_pkg::PARITY_IDX) begin
                parity_next = in_byte;
            end
            if (cnt == mfpp_pkg::TARGET_IDX) begin
                acc_next = in_byte;
            end else begin
                acc_next = acc_reg ^ in_byte;
            end
            if (cnt == mfpp_pkg::TYPE_IDX) begin
                type_next = in_byte;
                if ((in_byte != mfpp_pkg::TYPE_POS) && (in_byte != mfpp_pkg::TYPE_POS_DES)) begin
                    open_next = 1'b0;
                end
            end
            if (cnt == mfpp_pkg::LAST_IDX) begin
                open_next = 1'b0;
                res.valid = ((acc_reg ^ in_byte) == parity_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            count_reg <= 5'd0;
        end else begin
            open_reg  <= open_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        parity_reg <= parity_next;
        acc_reg    <= acc_next;
        type_reg   <= type_next;
        if (take && (cnt >= mfpp_pkg::HEADER_LEN) && (cnt <= mfpp_pkg::DATA_END)) begin
            data_reg[data_idx] <= in_byte;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (count_reg <= mfpp_pkg::LAST_IDX))
        else $error("Open frame holds more bytes than a frame has.");

    a_res_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (take && (cnt == mfpp_pkg::LAST_IDX)))
        else $error("Result raised before the last byte of a frame.");

    a_close_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && open_reg && (count_reg == mfpp_pkg::LAST_IDX)) |=> !open_reg)
        else $error("Frame stayed open after its last byte.");

    a_res_type: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> ((type_reg == mfpp_pkg::TYPE_POS) || (type_reg == mfpp_pkg::TYPE_POS_DES)))
        else $error("Result raised for a frame of unknown type.");

endmodule

`default_nettype wire

FILE: src/mfpp_out_reg.sv
`default_nettype none

module mfpp_out_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire mfpp_pkg::res_t res,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_frame_kind,
    output logic [31:0]         m_x_word,
    output logic [31:0]         m_y_word,
    output logic [31:0]         m_z_word
);

    logic           valid_reg;
    logic           valid_next;
    mfpp_pkg::res_t data_reg;

    assign valid_next = load ? res.valid : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.valid) begin
            data_reg <= res;
        end
    end

    assign m_valid      = valid_reg;
    assign m_frame_kind = data_reg.kind;
    assign m_x_word     = data_reg.x_word;
    assign m_y_word     = data_reg.y_word;
    assign m_z_word     = data_reg.z_word;

endmodule

`default_nettype wire

FILE: src/marker_framed_position_parser.sv
// Path: a byte that completes a valid frame is held in the input register, then its result
// is registered in the result register and offered on m_valid.
// Throughput: one byte per cycle while the result register is empty or m_ready is high.
// While a result waits, one further byte is taken into the input register, then input stalls.
// Reset (aresetn low, synchronous) closes any open frame and empties both registers.
`default_nettype none

module marker_framed_position_parser (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_frame_kind,
    output logic [31:0]     m_x_word,
    output logic [31:0]     m_y_word,
    output logic [31:0]     m_z_word
);

    logic           in_valid;
    logic [7:0]     in_byte;
    logic           advance;
    mfpp_pkg::res_t res;

    assign advance = in_valid && (!m_valid || m_ready);

    mfpp_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    mfpp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .in_byte (in_byte),
        .res     (res)
    );

    mfpp_out_reg u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (advance),
        .res          (res),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_kind (m_frame_kind),
        .m_x_word     (m_x_word),
        .m_y_word     (m_y_word),
        .m_z_word     (m_z_word)
    );

endmodule

`default_nettype wire
